// ===== design/cnfs_pkg.sv =====
// ----------------------------------------------------------------------------
// cnfs_pkg: shared types, constants and calendar helpers
// Holds the controller/datapath command and status words, the state type,
// register indexes and the small calendar tables used by the search.
// ----------------------------------------------------------------------------
package cnfs_pkg;

   localparam int unsigned STEP_LIMIT = 535680;
   localparam int unsigned STEP_W     = $clog2(STEP_LIMIT + 1);

   localparam logic [13:0] YEAR_MIN = 14'd1970;
   localparam logic [13:0] YEAR_MAX = 14'd9999;

   // year / 100 as (year * RECIP) >> RECIP_SHIFT, exact for any 14-bit year
   localparam logic [12:0] RECIP       = 13'd5243;
   localparam int unsigned RECIP_SHIFT = 19;

   localparam int unsigned CSR_ADDR_W = 6;
   localparam int unsigned CSR_DATA_W = 64;

   typedef enum logic [2:0] {
      CSR_MINUTE  = 3'd0,
      CSR_HOUR    = 3'd1,
      CSR_DAY     = 3'd2,
      CSR_MONTH   = 3'd3,
      CSR_WEEKDAY = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_CHECK,
      ST_SEARCH,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic load;      // capture the start word
      logic prep;      // split the year into century and year of century
      logic check;     // validate start, latch start match, clear step count
      logic step;      // take one calendar skip
      logic finish;    // latch the search outcome
      logic found;     // outcome that goes with finish
      logic out_load;  // move the outcome into the result register
   } cmd_type;

   typedef struct packed {
      logic valid;     // start fields form a legal date and time
      logic hit;       // current position matches all masks
      logic ovf;       // the pending skip would leave year 9999
      logic limit;     // step budget spent
   } status_type;

   function automatic logic [4:0] month_days(input logic [3:0] mo, input logic leap);
      logic [4:0] d;
      case (mo)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   d = 5'd30;
         4'd2:                                      d = leap ? 5'd29 : 5'd28;
         default:                                   d = 5'd0;
      endcase
      return d;
   endfunction

   // reduce a value below 42 modulo 7 by repeated compare and subtract
   function automatic logic [2:0] mod7(input logic [5:0] v);
      logic [5:0] r;
      r = v;
      for (int i = 0; i < 5; i++) begin
         if (r >= 6'd7) begin
            r = r - 6'd7;
         end
      end
      return r[2:0];
   endfunction

endpackage

// ===== design/cnfs_csr.sv =====
// ----------------------------------------------------------------------------
// cnfs_csr: schedule mask registers
// Five cron masks behind a 64-bit register port, all ones after reset.
// ----------------------------------------------------------------------------
module cnfs_csr
   import cnfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [59:0]           minute_mask,
   output logic [23:0]           hour_mask,
   output logic [30:0]           day_mask,
   output logic [11:0]           month_mask,
   output logic [6:0]            weekday_mask
);

   logic [59:0] minute_ff, minute_in;
   logic [23:0] hour_ff, hour_in;
   logic [30:0] day_ff, day_in;
   logic [11:0] month_ff, month_in;
   logic [6:0]  weekday_ff, weekday_in;
   logic        wr_en;
   logic [2:0]  index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign index      = csr_paddr[5:3];

   always_comb begin
      minute_in  = minute_ff;
      hour_in    = hour_ff;
      day_in     = day_ff;
      month_in   = month_ff;
      weekday_in = weekday_ff;
      if (wr_en) begin
         unique case (index)
            CSR_MINUTE:  minute_in  = csr_pwdata[59:0];
            CSR_HOUR:    hour_in    = csr_pwdata[23:0];
            CSR_DAY:     day_in     = csr_pwdata[30:0];
            CSR_MONTH:   month_in   = csr_pwdata[11:0];
            CSR_WEEKDAY: weekday_in = csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         minute_ff  <= '1;
         hour_ff    <= '1;
         day_ff     <= '1;
         month_ff   <= '1;
         weekday_ff <= '1;
      end else begin
         minute_ff  <= minute_in;
         hour_ff    <= hour_in;
         day_ff     <= day_in;
         month_ff   <= month_in;
         weekday_ff <= weekday_in;
      end
   end

   always_comb begin
      unique case (index)
         CSR_MINUTE:  csr_prdata = {4'd0, minute_ff};
         CSR_HOUR:    csr_prdata = {40'd0, hour_ff};
         CSR_DAY:     csr_prdata = {33'd0, day_ff};
         CSR_MONTH:   csr_prdata = {52'd0, month_ff};
         CSR_WEEKDAY: csr_prdata = {57'd0, weekday_ff};
         default:     csr_prdata = '0;
      endcase
   end

   assign minute_mask  = minute_ff;
   assign hour_mask    = hour_ff;
   assign day_mask     = day_ff;
   assign month_mask   = month_ff;
   assign weekday_mask = weekday_ff;

endmodule

// ===== design/cnfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// cnfs_ctrl: search sequencer
// Steps one item through prepare, check, search and delivery, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module cnfs_ctrl
   import cnfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (!status.valid) begin
               cmd.finish = 1'b1;
               state_in   = ST_DELIVER;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.limit) begin
               cmd.finish = 1'b1;
               state_in   = ST_DELIVER;
            end else if (status.hit) begin
               cmd.finish = 1'b1;
               cmd.found  = 1'b1;
               state_in   = ST_DELIVER;
            end else if (status.ovf) begin
               cmd.finish = 1'b1;
               state_in   = ST_DELIVER;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_DELIVER: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== design/cnfs_dp.sv =====
// ----------------------------------------------------------------------------
// cnfs_dp: calendar datapath
// Holds the running calendar position, tests it against the masks and takes
// one skip per command. Also holds the step count and the result register.
// ----------------------------------------------------------------------------
module cnfs_dp
   import cnfs_pkg::*;
(
   input  logic        clock,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [13:0] start_year,
   input  logic [3:0]  start_month,
   input  logic [4:0]  start_day,
   input  logic [4:0]  start_hour,
   input  logic [5:0]  start_minute,
   input  logic [2:0]  start_weekday,
   input  logic [59:0] minute_mask,
   input  logic [23:0] hour_mask,
   input  logic [30:0] day_mask,
   input  logic [11:0] month_mask,
   input  logic [6:0]  weekday_mask,
   output logic        found,
   output logic        start_matches,
   output logic [13:0] next_year,
   output logic [3:0]  next_month,
   output logic [4:0]  next_day,
   output logic [4:0]  next_hour,
   output logic [5:0]  next_minute,
   output logic [2:0]  next_weekday
);

   logic [13:0]       yr_ff, yr_in;
   logic [3:0]        mo_ff, mo_in;
   logic [4:0]        day_ff, day_in;
   logic [4:0]        hr_ff, hr_in;
   logic [5:0]        mi_ff, mi_in;
   logic [2:0]        wd_ff, wd_in;
   logic [7:0]        cent_ff, cent_in;
   logic [6:0]        ymod_ff, ymod_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic              start_ok_ff, start_ok_in;
   logic              found_ff, found_in;
   logic [38:0]       out_ff, out_in;

   logic [26:0] cent_prod;
   logic [13:0] cent_x100;
   logic        leap;
   logic [4:0]  dim;
   logic [15:0] month_ext;
   logic [31:0] day_ext, hour_ext;
   logic [63:0] minute_ext;
   logic [7:0]  wd_ext;
   logic        mon_ok, dom_ok, dow_ok, day_ok, hr_ok, mi_ok;
   logic        k_month, k_day, k_hour, k_min;
   logic        carry_hour, carry_day, carry_month, carry_year;
   logic [5:0]  skip;
   logic        valid;

   // pad the masks so every index lands on a defined bit
   assign month_ext  = {4'd0, month_mask};
   assign day_ext    = {1'b0, day_mask};
   assign hour_ext   = {8'd0, hour_mask};
   assign minute_ext = {4'd0, minute_mask};
   assign wd_ext     = {1'b0, weekday_mask};

   assign cent_prod = 27'(start_year) * 27'(RECIP);
   assign cent_x100 = 14'({cent_ff, 6'd0}) + 14'({cent_ff, 5'd0}) + 14'({cent_ff, 2'd0});

   assign leap = (yr_ff[1:0] == 2'd0) && ((ymod_ff != 7'd0) || (cent_ff[1:0] == 2'd0));
   assign dim  = month_days(mo_ff, leap);

   assign mon_ok = month_ext[4'(mo_ff - 4'd1)];
   assign dom_ok = day_ext[5'(day_ff - 5'd1)];
   assign dow_ok = wd_ext[wd_ff];
   assign hr_ok  = hour_ext[hr_ff];
   assign mi_ok  = minute_ext[mi_ff];

   always_comb begin
      if (&day_mask && &weekday_mask) begin
         day_ok = 1'b1;
      end else if (&day_mask) begin
         day_ok = dow_ok;
      end else if (&weekday_mask) begin
         day_ok = dom_ok;
      end else begin
         day_ok = dom_ok || dow_ok;
      end
   end

   assign valid = (yr_ff >= YEAR_MIN) && (yr_ff <= YEAR_MAX) &&
                  (day_ff != 5'd0) && (day_ff <= dim) &&
                  (hr_ff <= 5'd23) && (mi_ff <= 6'd59) && (wd_ff <= 3'd6);

   // skip kind, first barred field wins
   assign k_month = !mon_ok;
   assign k_day   = mon_ok && !day_ok;
   assign k_hour  = mon_ok && day_ok && !hr_ok;
   assign k_min   = mon_ok && day_ok && hr_ok && !mi_ok;

   assign carry_hour  = k_min && (mi_ff == 6'd59);
   assign carry_day   = k_day || ((k_hour || carry_hour) && (hr_ff == 5'd23));
   assign carry_month = k_month || (carry_day && (day_ff == dim));
   assign carry_year  = carry_month && (mo_ff == 4'd12);

   assign skip = 6'({1'b0, dim} - {1'b0, day_ff} + 6'd1);

   assign status.valid = valid;
   assign status.hit   = mon_ok && day_ok && hr_ok && mi_ok;
   assign status.ovf   = carry_year && (yr_ff >= YEAR_MAX);
   assign status.limit = (steps_ff == STEP_W'(STEP_LIMIT));

   always_comb begin
      yr_in       = yr_ff;
      mo_in       = mo_ff;
      day_in      = day_ff;
      hr_in       = hr_ff;
      mi_in       = mi_ff;
      wd_in       = wd_ff;
      cent_in     = cent_ff;
      ymod_in     = ymod_ff;
      steps_in    = steps_ff;
      start_ok_in = start_ok_ff;
      found_in    = found_ff;
      out_in      = out_ff;

      if (cmd.load) begin
         yr_in   = start_year;
         mo_in   = start_month;
         day_in  = start_day;
         hr_in   = start_hour;
         mi_in   = start_minute;
         wd_in   = start_weekday;
         cent_in = cent_prod[RECIP_SHIFT +: 8];
      end

      if (cmd.prep) begin
         ymod_in = 7'(yr_ff - cent_x100);
      end

      if (cmd.check) begin
         start_ok_in = valid && status.hit;
         steps_in    = '0;
      end

      if (cmd.step) begin
         steps_in = STEP_W'(steps_ff + 1'b1);

         if (k_min && !carry_hour) begin
            mi_in = 6'(mi_ff + 6'd1);
         end else begin
            mi_in = '0;
         end

         if (k_month || carry_day) begin
            hr_in = '0;
         end else if (k_hour || carry_hour) begin
            hr_in = 5'(hr_ff + 5'd1);
         end

         if (carry_month) begin
            day_in = 5'd1;
         end else if (carry_day) begin
            day_in = 5'(day_ff + 5'd1);
         end

         if (k_month) begin
            wd_in = mod7(6'({3'd0, wd_ff} + skip));
         end else if (carry_day) begin
            wd_in = (wd_ff == 3'd6) ? 3'd0 : 3'(wd_ff + 3'd1);
         end

         if (carry_year) begin
            mo_in = 4'd1;
            yr_in = 14'(yr_ff + 14'd1);
            if (ymod_ff == 7'd99) begin
               ymod_in = '0;
               cent_in = 8'(cent_ff + 8'd1);
            end else begin
               ymod_in = 7'(ymod_ff + 7'd1);
            end
         end else if (carry_month) begin
            mo_in = 4'(mo_ff + 4'd1);
         end
      end

      if (cmd.finish) begin
         found_in = cmd.found;
      end

      if (cmd.out_load) begin
         if (found_ff) begin
            out_in = {wd_ff, mi_ff, hr_ff, day_ff, mo_ff, yr_ff, start_ok_ff, 1'b1};
         end else begin
            out_in = {37'd0, start_ok_ff, 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      yr_ff       <= yr_in;
      mo_ff       <= mo_in;
      day_ff      <= day_in;
      hr_ff       <= hr_in;
      mi_ff       <= mi_in;
      wd_ff       <= wd_in;
      cent_ff     <= cent_in;
      ymod_ff     <= ymod_in;
      steps_ff    <= steps_in;
      start_ok_ff <= start_ok_in;
      found_ff    <= found_in;
      out_ff      <= out_in;
   end

   assign found         = out_ff[0];
   assign start_matches = out_ff[1];
   assign next_year     = out_ff[15:2];
   assign next_month    = out_ff[19:16];
   assign next_day      = out_ff[24:20];
   assign next_hour     = out_ff[29:25];
   assign next_minute   = out_ff[35:30];
   assign next_weekday  = out_ff[38:36];

endmodule

// ===== design/cron_next_fire_search_top.sv =====
// ----------------------------------------------------------------------------
// cron_next_fire_search_top: next cron fire time search
// Takes a start minute as calendar fields and walks forward, one calendar
// skip per cycle, to the first minute allowed by five cron masks.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake            Word
//  req      in   tvalid/tready        start year, month, day, hour, minute, weekday
//  rsp      out  tvalid/tready        found, start match, next calendar fields
//  csr      in   psel/penable/pready  64-bit mask registers at 8*index
//
//  A word that is taken passes through prepare, check, n calendar skips plus
//  the final test, and deliver; an illegal start goes from check straight to
//  deliver. n is at most 535680. The engine then returns to idle, where the
//  next word is taken. Reset is synchronous; masks come back all ones.
//  The result register frees the engine: a new word is taken while the last
//  result still waits, and the engine holds only when a second one is ready.
//
module cron_next_fire_search_top
   import cnfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [13:0] start_year, [17:14] start_month, [22:18] start_day,
   // [27:23] start_hour, [33:28] start_minute, [36:34] start_weekday
   input  logic [39:0]           req_tdata,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] found, [1] start_matches, [15:2] next_year, [19:16] next_month,
   // [24:20] next_day, [29:25] next_hour, [35:30] next_minute,
   // [38:36] next_weekday
   output logic [39:0]           rsp_tdata,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [59:0] minute_mask;
   logic [23:0] hour_mask;
   logic [30:0] day_mask;
   logic [11:0] month_mask;
   logic [6:0]  weekday_mask;

   cmd_type    cmd;
   status_type status;

   logic        found;
   logic        start_matches;
   logic [13:0] next_year;
   logic [3:0]  next_month;
   logic [4:0]  next_day;
   logic [4:0]  next_hour;
   logic [5:0]  next_minute;
   logic [2:0]  next_weekday;

   // mask registers
   cnfs_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .minute_mask  (minute_mask),
      .hour_mask    (hour_mask),
      .day_mask     (day_mask),
      .month_mask   (month_mask),
      .weekday_mask (weekday_mask)
   );

   // sequence prepare, check, search and delivery
   cnfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // calendar position, skip logic and result register
   cnfs_dp u_dp (
      .clock         (clock),
      .cmd           (cmd),
      .status        (status),
      .start_year    (req_tdata[13:0]),
      .start_month   (req_tdata[17:14]),
      .start_day     (req_tdata[22:18]),
      .start_hour    (req_tdata[27:23]),
      .start_minute  (req_tdata[33:28]),
      .start_weekday (req_tdata[36:34]),
      .minute_mask   (minute_mask),
      .hour_mask     (hour_mask),
      .day_mask      (day_mask),
      .month_mask    (month_mask),
      .weekday_mask  (weekday_mask),
      .found         (found),
      .start_matches (start_matches),
      .next_year     (next_year),
      .next_month    (next_month),
      .next_day      (next_day),
      .next_hour     (next_hour),
      .next_minute   (next_minute),
      .next_weekday  (next_weekday)
   );

   // pack the result word, lowest field first, pad to whole bytes
   assign rsp_tdata = {1'b0, next_weekday, next_minute, next_hour, next_day,
                       next_month, next_year, start_matches, found};

endmodule

// ===== test/fire_time_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fire_time_checker: next fire time prediction and result compare
// Tracks the cron mask registers from the register port, works out the next
// fire time for every accepted start word and compares each result word,
// field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module fire_time_checker
   import cnfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [39:0]           req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [39:0]           rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    mismatches,
   output int                    outstanding
);

   localparam int unsigned SKIP_BUDGET = 535680;
   localparam int          FIRST_YEAR  = 1970;
   localparam int          LAST_YEAR   = 9999;

   typedef struct packed {
      logic        found;
      logic        start_hit;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [2:0]  weekday;
   } fire_type;

   logic [59:0] minute_allow;
   logic [23:0] hour_allow;
   logic [30:0] day_allow;
   logic [11:0] month_allow;
   logic [6:0]  weekday_allow;

   fire_type due_fire_q[$];
   fire_type got_fire;
   fire_type want_fire;

   function automatic bit leap_year(input int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int month_length(input int y, input int mo);
      int n;
      case (mo)
         1, 3, 5, 7, 8, 10, 12: n = 31;
         4, 6, 9, 11:           n = 30;
         2:                     n = leap_year(y) ? 29 : 28;
         default:               n = 0;
      endcase
      return n;
   endfunction

   // a fully set mask hands the decision to the other one
   function automatic bit day_allowed(input int d, input int wd);
      bit dom_all;
      bit dow_all;
      dom_all = &day_allow;
      dow_all = &weekday_allow;
      if (dom_all && dow_all) return 1'b1;
      if (dom_all) return weekday_allow[wd];
      if (dow_all) return day_allow[d-1];
      return day_allow[d-1] || weekday_allow[wd];
   endfunction

   function automatic bit schedule_hit(input int mo, input int d, input int h, input int mi,
                                       input int wd);
      return month_allow[mo-1] && day_allowed(d, wd) && hour_allow[h] && minute_allow[mi];
   endfunction

   function automatic fire_type next_fire_of(input logic [39:0] word);
      int          y, mo, d, h, mi, wd;
      int unsigned skips;
      bit          roll_day, roll_month;
      fire_type    r;
      y  = int'(word[13:0]);
      mo = int'(word[17:14]);
      d  = int'(word[22:18]);
      h  = int'(word[27:23]);
      mi = int'(word[33:28]);
      wd = int'(word[36:34]);
      r  = '0;
      if (y < FIRST_YEAR || y > LAST_YEAR || mo < 1 || mo > 12 || d < 1 ||
          d > month_length(y, mo) || h > 23 || mi > 59 || wd > 6) begin
         return r;
      end
      r.start_hit = schedule_hit(mo, d, h, mi, wd);
      skips = 0;
      while (skips < SKIP_BUDGET) begin
         roll_day   = 1'b0;
         roll_month = 1'b0;
         if (!month_allow[mo-1]) begin
            wd = (wd + month_length(y, mo) - d + 1) % 7;
            d  = 1;
            h  = 0;
            mi = 0;
            roll_month = 1'b1;
         end else if (!day_allowed(d, wd)) begin
            roll_day = 1'b1;
         end else if (!hour_allow[h]) begin
            mi = 0;
            h++;
            roll_day = (h > 23);
         end else if (!minute_allow[mi]) begin
            mi++;
            if (mi > 59) begin
               mi = 0;
               h++;
               roll_day = (h > 23);
            end
         end else begin
            r.found   = 1'b1;
            r.year    = y[13:0];
            r.month   = mo[3:0];
            r.day     = d[4:0];
            r.hour    = h[4:0];
            r.minute  = mi[5:0];
            r.weekday = wd[2:0];
            break;
         end
         if (roll_day) begin
            h  = 0;
            mi = 0;
            wd = (wd + 1) % 7;
            d++;
            if (d > month_length(y, mo)) begin
               d = 1;
               roll_month = 1'b1;
            end
         end
         if (roll_month) begin
            mo++;
            if (mo > 12) begin
               // stepping into year 10000 ends the search empty handed
               if (y >= LAST_YEAR) break;
               mo = 1;
               y++;
            end
         end
         skips++;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("checker: %s", msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         minute_allow  <= '1;
         hour_allow    <= '1;
         day_allow     <= '1;
         month_allow   <= '1;
         weekday_allow <= '1;
         due_fire_q.delete();
         mismatches = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[2:0] == 3'b000) begin
            case (csr_paddr[5:3])
               CSR_MINUTE:  minute_allow  <= csr_pwdata[59:0];
               CSR_HOUR:    hour_allow    <= csr_pwdata[23:0];
               CSR_DAY:     day_allow     <= csr_pwdata[30:0];
               CSR_MONTH:   month_allow   <= csr_pwdata[11:0];
               CSR_WEEKDAY: weekday_allow <= csr_pwdata[6:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            due_fire_q.push_back(next_fire_of(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got_fire.found     = rsp_tdata[0];
            got_fire.start_hit = rsp_tdata[1];
            got_fire.year      = rsp_tdata[15:2];
            got_fire.month     = rsp_tdata[19:16];
            got_fire.day       = rsp_tdata[24:20];
            got_fire.hour      = rsp_tdata[29:25];
            got_fire.minute    = rsp_tdata[35:30];
            got_fire.weekday   = rsp_tdata[38:36];
            if (due_fire_q.size() == 0) begin
               report_mismatch("result word with no start word waiting");
            end else begin
               want_fire = due_fire_q.pop_front();
               check_field("found", got_fire.found, want_fire.found);
               check_field("start_matches", got_fire.start_hit, want_fire.start_hit);
               check_field("next_year", got_fire.year, want_fire.year);
               check_field("next_month", got_fire.month, want_fire.month);
               check_field("next_day", got_fire.day, want_fire.day);
               check_field("next_hour", got_fire.hour, want_fire.hour);
               check_field("next_minute", got_fire.minute, want_fire.minute);
               check_field("next_weekday", got_fire.weekday, want_fire.weekday);
            end
         end
      end
      outstanding <= due_fire_q.size();
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: cron next fire search top level test
// Programs the five cron masks through the register port, drives directed
// and random start words with random idle and stall cycles, and gives the
// verdict from the mismatch count of the checker.
// ----------------------------------------------------------------------------
module testbench;
   import cnfs_pkg::*;

   localparam int          RANDOM_PHASES = 8;
   localparam int          PHASE_WORDS   = 113;
   localparam logic [63:0] MINUTE_ALL    = 64'h0FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] HOUR_ALL      = 64'h00FF_FFFF;
   localparam logic [63:0] DAY_ALL       = 64'h7FFF_FFFF;
   localparam logic [63:0] MONTH_ALL     = 64'h0FFF;
   localparam logic [63:0] WEEKDAY_ALL   = 64'h7F;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic [39:0]           req_tdata   = '0;
   logic                  rsp_tready  = 1'b0;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;

   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [39:0]           rsp_tdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatches;
   int outstanding;

   // while set, neither side inserts idle or stall cycles
   bit steady = 1'b0;

   always #5 clock = ~clock;

   cron_next_fire_search_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   fire_time_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Stall the result side about one cycle in ten.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 10);
   end

   // Pack the start fields, year in the lowest bits, pad bits zero.
   function automatic logic [39:0] start_word(input int y, input int mo, input int d,
                                              input int h, input int mi, input int wd);
      return {3'b000, wd[2:0], mi[5:0], h[4:0], d[4:0], mo[3:0], y[13:0]};
   endfunction

   function automatic int days_of(input int y, input int mo);
      int n;
      case (mo)
         4, 6, 9, 11: n = 30;
         2:           n = ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
         default:     n = 31;
      endcase
      return n;
   endfunction

   // Mostly legal start times with a lean toward month, hour and year ends;
   // the rest is raw noise across every field bit.
   function automatic logic [39:0] random_start();
      logic [63:0] noise;
      int          y, mo, d, h, mi, wd, pick;
      noise = {$urandom, $urandom};
      if ($urandom_range(99) < 10) begin
         return {3'b000, noise[36:0]};
      end
      pick = $urandom_range(19);
      if (pick == 0) begin
         y = $urandom_range(1975, 1970);
      end else if (pick == 1) begin
         y = $urandom_range(9999, 9990);
      end else begin
         y = $urandom_range(9999, 1970);
      end
      mo = $urandom_range(12, 1);
      if ($urandom_range(99) < 30) begin
         d = days_of(y, mo) - $urandom_range(2);
      end else begin
         d = $urandom_range(days_of(y, mo), 1);
      end
      h  = ($urandom_range(99) < 20) ? 23 : $urandom_range(23);
      mi = ($urandom_range(99) < 20) ? 59 : $urandom_range(59);
      wd = $urandom_range(6);
      return start_word(y, mo, d, h, mi, wd);
   endfunction

   // Pick a mask shape: full, one bit, two bits, dense, sparse or all but one.
   function automatic logic [63:0] random_mask(input int width);
      logic [63:0] full, one, m;
      full = (64'd1 << width) - 64'd1;
      one  = 64'd1 << $urandom_range(width - 1);
      case ($urandom_range(5))
         0:       m = full;
         1:       m = one;
         2:       m = one | (64'd1 << $urandom_range(width - 1));
         3:       m = ({$urandom, $urandom} & full) | one;
         4:       m = ({$urandom, $urandom} & {$urandom, $urandom} & full) | one;
         default: m = full & ~one;
      endcase
      return m;
   endfunction

   // Present one start word and hold it until it is taken; idle in front of
   // it at random. Valid stays high across back to back words.
   task automatic send_start(input logic [39:0] word);
      while (!steady && $urandom_range(99) < 10) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and hold until every predicted result word is back, then
   // give the engine more time before anything is reprogrammed.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Setup phase, access phase, then an idle phase with psel low so that back
   // to back writes never assign psel twice in one step.
   task automatic write_mask(input csr_index_type idx, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_schedule(input logic [63:0] minute_m, input logic [63:0] hour_m,
                               input logic [63:0] day_m, input logic [63:0] month_m,
                               input logic [63:0] weekday_m);
      write_mask(CSR_MINUTE, minute_m);
      write_mask(CSR_HOUR, hour_m);
      write_mask(CSR_DAY, day_m);
      write_mask(CSR_MONTH, month_m);
      write_mask(CSR_WEEKDAY, weekday_m);
   endtask

   // Add junk above a mask's width now and then; the block must drop it.
   function automatic logic [63:0] with_junk(input logic [63:0] m, input int width);
      logic [63:0] full;
      full = (64'd1 << width) - 64'd1;
      if ($urandom_range(1) == 0) return m;
      return m | ({$urandom, $urandom} & ~full);
   endfunction

   initial begin
      logic [63:0] minute_m, hour_m, day_m, month_m, weekday_m;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Everything allowed: legal corners, leap days and each kind of
      // illegal start field.
      set_schedule(MINUTE_ALL, HOUR_ALL, DAY_ALL, MONTH_ALL, WEEKDAY_ALL);
      send_start(start_word(1970, 1, 1, 0, 0, 4));
      send_start(start_word(9999, 12, 31, 23, 59, 5));
      send_start(start_word(2024, 2, 29, 12, 30, 4));
      send_start(start_word(2000, 2, 29, 6, 7, 2));
      send_start(start_word(1969, 12, 31, 23, 59, 3));
      send_start(start_word(16383, 1, 1, 0, 0, 0));
      send_start(start_word(2020, 0, 10, 1, 1, 1));
      send_start(start_word(2020, 15, 10, 1, 1, 1));
      send_start(start_word(2100, 2, 29, 0, 0, 1));
      send_start(start_word(2021, 4, 0, 5, 5, 2));
      send_start(start_word(2021, 4, 31, 5, 5, 2));
      send_start(start_word(2021, 5, 1, 24, 0, 6));
      send_start(start_word(2021, 5, 1, 10, 60, 6));
      send_start(start_word(2021, 5, 1, 10, 10, 7));
      // weekday that does not fit the date is carried along as given
      send_start(start_word(2024, 1, 1, 8, 8, 6));
      drain();

      // No minute allowed: one skip into year 10000, then a full budget of
      // minute skips from the first possible start.
      write_mask(CSR_MINUTE, 64'd0);
      send_start(start_word(9999, 12, 31, 23, 59, 5));
      send_start(start_word(1970, 1, 1, 0, 0, 4));
      drain();

      // No month allowed: month skips run off the end of year 9999.
      set_schedule(MINUTE_ALL, 64'd0, 64'd0, 64'd0, 64'd0);
      send_start(start_word(9998, 11, 20, 10, 10, 5));
      drain();

      // No hour allowed: hour skips roll over the last day of 9999.
      set_schedule(MINUTE_ALL, 64'd0, DAY_ALL, MONTH_ALL, WEEKDAY_ALL);
      send_start(start_word(9999, 12, 31, 20, 5, 5));
      drain();

      // Edge bits only: first and last minute, hour, month; day 31 alone.
      set_schedule(64'h0800_0000_0000_0001, 64'h0080_0001, 64'h4000_0000, 64'h0801, 64'd0);
      send_start(start_word(2023, 2, 1, 12, 0, 3));
      send_start(start_word(2023, 12, 31, 23, 59, 0));
      send_start(start_word(2023, 12, 31, 23, 58, 0));
      send_start(start_word(2024, 12, 31, 0, 30, 2));
      drain();

      // Only the weekday decides, then day of month OR weekday.
      set_schedule(MINUTE_ALL, HOUR_ALL, DAY_ALL, MONTH_ALL, 64'h40);
      send_start(start_word(2024, 3, 6, 7, 0, 3));
      drain();
      set_schedule(MINUTE_ALL, HOUR_ALL, 64'h4000, MONTH_ALL, 64'h01);
      send_start(start_word(2024, 3, 11, 9, 15, 1));
      drain();

      // Random schedules. Keep each one satisfiable: a weekday is always
      // allowed, and a day that every month has whenever the weekday mask
      // leaves the choice to the day mask.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         steady = (p == 3);
         if (p == 0) begin
            minute_m  = MINUTE_ALL;
            hour_m    = HOUR_ALL;
            day_m     = DAY_ALL;
            month_m   = MONTH_ALL;
            weekday_m = WEEKDAY_ALL;
         end else begin
            minute_m  = random_mask(60);
            hour_m    = random_mask(24);
            day_m     = random_mask(31);
            month_m   = random_mask(12);
            weekday_m = random_mask(7);
            if (weekday_m == WEEKDAY_ALL && day_m[27:0] == 28'd0) begin
               day_m = day_m | (64'd1 << $urandom_range(27));
            end
         end
         set_schedule(with_junk(minute_m, 60), with_junk(hour_m, 24), with_junk(day_m, 31),
                      with_junk(month_m, 12), with_junk(weekday_m, 7));
         for (int i = 0; i < PHASE_WORDS; i++) begin
            send_start(random_start());
         end
         drain();
      end
      steady = 1'b0;

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #(60_000_000);
      $display("tb: failure");
      $finish;
   end

endmodule
